/* rtl/xxh32_pkg.sv */
// xxh32_pkg: constants, command and status types and helper functions
// shared by the xxhash32 controller, datapath and top level
// depends on nothing
`timescale 1ns / 1ps

package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    // datapath operation codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_LANE   = 4'd2;
    localparam logic [3:0] OP_INIT   = 4'd3;
    localparam logic [3:0] OP_TW_MUL = 4'd4;
    localparam logic [3:0] OP_TW_RND = 4'd5;
    localparam logic [3:0] OP_TB_MUL = 4'd6;
    localparam logic [3:0] OP_TB_RND = 4'd7;
    localparam logic [3:0] OP_AV1    = 4'd8;
    localparam logic [3:0] OP_AV2    = 4'd9;
    localparam logic [3:0] OP_DONE   = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
    } xxh32_cmd_t;

    typedef struct packed {
        logic [1:0] words;   // buffered whole words
        logic [2:0] count;   // clamped byte count of the latest word
    } xxh32_status_t;

    typedef logic [3:0][31:0] xxh32_lanes_t;

    // words that are not last, and counts above four, count as four bytes
    function automatic logic [2:0] clamp_count(input logic [2:0] bc, input logic is_last);
        logic [2:0] c;
        c = bc;
        if (!is_last || bc > FULL_COUNT)
            c = FULL_COUNT;
        return c;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic xxh32_lanes_t lane_init(input logic [31:0] s);
        xxh32_lanes_t l;
        l[0] = s + PRIME1 + PRIME2;
        l[1] = s + PRIME2;
        l[2] = s;
        l[3] = s - PRIME1;
        return l;
    endfunction

endpackage

/* rtl/xxhash32_stream_hasher_core.sv */
// xxhash32_stream_hasher_core: seeded xxhash32 over a stream of 32-bit words.
// a word that is not last is accepted, then gets a lane round; accept, the
// lane round, the tail rounds and AV1/AV2 share one 32x32 multiplier. a last
// word then gets a lane round if full, an init step, a multiply and a round
// per buffered word and per loose byte, and the avalanche steps AV1, AV2, DONE.
// reset (rst_n, async low) clears the seed to 0 and loads lanes from it.
`timescale 1ns / 1ps

module xxhash32_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    // seed register write port
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input word channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    // hash result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    // command and status between the sequencer and the datapath
    xxh32_pkg::xxh32_cmd_t    cmd;
    xxh32_pkg::xxh32_status_t status;

    // sequencer: accepts input transactions only in its idle state, and
    // holds the final step while a previous hash is still waiting
    xxh32_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: lanes, stripe buffer, length, tail hash and output register;
    // a seed write with no word of the message seen reloads the lanes
    xxh32_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .hash_value  (hash_value)
    );

endmodule

/* rtl/xxh32_datapath.sv */
// xxh32_datapath: lane accumulators, stripe buffer, hash register and the
// one shared 32x32 multiplier, driven by commands from the controller
// depends on xxh32_pkg
`timescale 1ns / 1ps

module xxh32_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [31:0]             cfg_wr_data,
    input  logic [31:0]             data_word,
    input  logic [2:0]              byte_count,
    input  logic                    last,
    input  xxh32_pkg::xxh32_cmd_t   cmd,
    output xxh32_pkg::xxh32_status_t status,
    output logic [31:0]             hash_value
);

    logic [31:0]              seed_reg;
    xxh32_pkg::xxh32_lanes_t  lane_reg;
    logic [31:0]              pend_reg [3];
    logic [31:0]              buf_reg [3];
    logic [1:0]               bufcnt_reg;
    logic [31:0]              len_reg;
    logic                     seen_reg;
    logic [31:0]              word_reg;
    logic [2:0]               cnt_reg;
    logic [31:0]              mul_reg;
    logic [31:0]              h_reg;
    logic [31:0]              hash_reg;

    logic [2:0]  cnt_in;
    logic        full_in;
    logic        msg_empty;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_out;
    logic [31:0] conv;
    logic [31:0] h_base;

    assign cnt_in    = xxh32_pkg::clamp_count(byte_count, last);
    assign full_in   = (cnt_in == xxh32_pkg::FULL_COUNT);
    assign msg_empty = (bufcnt_reg == 2'd0) && (len_reg == 32'd0) && !seen_reg;

    assign conv = xxh32_pkg::rotl32(lane_reg[0], 1) + xxh32_pkg::rotl32(lane_reg[1], 7)
                + xxh32_pkg::rotl32(lane_reg[2], 12) + xxh32_pkg::rotl32(lane_reg[3], 18);
    assign h_base = seen_reg ? conv : (seed_reg + xxh32_pkg::PRIME5);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.op)
            xxh32_pkg::OP_ACCEPT:
            begin
                mul_a = data_word;
                mul_b = xxh32_pkg::PRIME2;
            end
            xxh32_pkg::OP_LANE:
            begin
                mul_a = xxh32_pkg::rotl32(lane_reg[bufcnt_reg] + mul_reg, 13);
                mul_b = xxh32_pkg::PRIME1;
            end
            xxh32_pkg::OP_TW_MUL:
            begin
                mul_a = buf_reg[cmd.idx];
                mul_b = xxh32_pkg::PRIME3;
            end
            xxh32_pkg::OP_TW_RND:
            begin
                mul_a = xxh32_pkg::rotl32(h_reg + mul_reg, 17);
                mul_b = xxh32_pkg::PRIME4;
            end
            xxh32_pkg::OP_TB_MUL:
            begin
                mul_a = {24'd0, word_reg[8*cmd.idx +: 8]};
                mul_b = xxh32_pkg::PRIME5;
            end
            xxh32_pkg::OP_TB_RND:
            begin
                mul_a = xxh32_pkg::rotl32(h_reg + mul_reg, 11);
                mul_b = xxh32_pkg::PRIME1;
            end
            xxh32_pkg::OP_AV1:
            begin
                mul_a = h_reg ^ (h_reg >> 15);
                mul_b = xxh32_pkg::PRIME2;
            end
            xxh32_pkg::OP_AV2:
            begin
                mul_a = h_reg ^ (h_reg >> 13);
                mul_b = xxh32_pkg::PRIME3;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // only the low half of the product is ever needed
    assign mul_out = mul_a * mul_b;

    // message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 32'd0;
            lane_reg   <= xxh32_pkg::lane_init(32'd0);
            bufcnt_reg <= 2'd0;
            len_reg    <= 32'd0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
                if (msg_empty)
                    lane_reg <= xxh32_pkg::lane_init(cfg_wr_data);
            end
            case (cmd.op)
                xxh32_pkg::OP_ACCEPT:
                    len_reg <= len_reg + {29'd0, cnt_in};
                xxh32_pkg::OP_LANE:
                begin
                    if (bufcnt_reg == 2'd3)
                    begin
                        lane_reg[0] <= pend_reg[0];
                        lane_reg[1] <= pend_reg[1];
                        lane_reg[2] <= pend_reg[2];
                        lane_reg[3] <= mul_out;
                        seen_reg    <= 1'b1;
                        bufcnt_reg  <= 2'd0;
                    end
                    else
                        bufcnt_reg <= bufcnt_reg + 2'd1;
                end
                xxh32_pkg::OP_DONE:
                begin
                    lane_reg   <= xxh32_pkg::lane_init(seed_reg);
                    bufcnt_reg <= 2'd0;
                    len_reg    <= 32'd0;
                    seen_reg   <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            xxh32_pkg::OP_ACCEPT:
            begin
                word_reg <= data_word;
                cnt_reg  <= cnt_in;
                mul_reg  <= mul_out;
                if (full_in && bufcnt_reg != 2'd3)
                    buf_reg[bufcnt_reg] <= data_word;
            end
            xxh32_pkg::OP_LANE:
            begin
                if (bufcnt_reg != 2'd3)
                    pend_reg[bufcnt_reg] <= mul_out;
            end
            xxh32_pkg::OP_INIT:
                h_reg <= h_base + len_reg;
            xxh32_pkg::OP_TW_MUL, xxh32_pkg::OP_TB_MUL:
                mul_reg <= mul_out;
            xxh32_pkg::OP_TW_RND, xxh32_pkg::OP_TB_RND,
            xxh32_pkg::OP_AV1, xxh32_pkg::OP_AV2:
                h_reg <= mul_out;
            xxh32_pkg::OP_DONE:
                hash_reg <= h_reg ^ (h_reg >> 16);
            default:
            begin
            end
        endcase
    end

    assign status.words = bufcnt_reg;
    assign status.count = cnt_reg;
    assign hash_value   = hash_reg;

endmodule

/* rtl/xxh32_ctrl.sv */
// xxh32_ctrl: state machine that sequences word intake, tail folding and
// avalanche, and owns both handshakes
// depends on xxh32_pkg
`timescale 1ns / 1ps

module xxh32_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               byte_count,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  xxh32_pkg::xxh32_status_t status,
    output xxh32_pkg::xxh32_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LANE = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_TWM  = 4'd3;
    localparam logic [3:0] S_TWR  = 4'd4;
    localparam logic [3:0] S_TBM  = 4'd5;
    localparam logic [3:0] S_TBR  = 4'd6;
    localparam logic [3:0] S_AV1  = 4'd7;
    localparam logic [3:0] S_AV2  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;

    logic [2:0] cnt_in;
    logic       bytes_left;
    logic [2:0] idx_inc;

    assign cnt_in     = xxh32_pkg::clamp_count(byte_count, last);
    assign bytes_left = (status.count != xxh32_pkg::FULL_COUNT) && (status.count != 3'd0);
    assign idx_inc    = {1'b0, idx_reg} + 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = xxh32_pkg::OP_NONE;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = xxh32_pkg::OP_ACCEPT;
                    last_next  = last;
                    state_next = (cnt_in == xxh32_pkg::FULL_COUNT) ? S_LANE : S_INIT;
                end
            end
            S_LANE:
            begin
                cmd.op     = xxh32_pkg::OP_LANE;
                state_next = last_reg ? S_INIT : S_IDLE;
            end
            S_INIT:
            begin
                cmd.op   = xxh32_pkg::OP_INIT;
                idx_next = 2'd0;
                if (status.words != 2'd0)
                    state_next = S_TWM;
                else if (bytes_left)
                    state_next = S_TBM;
                else
                    state_next = S_AV1;
            end
            S_TWM:
            begin
                cmd.op     = xxh32_pkg::OP_TW_MUL;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                cmd.op = xxh32_pkg::OP_TW_RND;
                if (idx_inc < {1'b0, status.words})
                begin
                    idx_next   = idx_inc[1:0];
                    state_next = S_TWM;
                end
                else
                begin
                    idx_next   = 2'd0;
                    state_next = bytes_left ? S_TBM : S_AV1;
                end
            end
            S_TBM:
            begin
                cmd.op     = xxh32_pkg::OP_TB_MUL;
                state_next = S_TBR;
            end
            S_TBR:
            begin
                cmd.op = xxh32_pkg::OP_TB_RND;
                if (idx_inc < status.count)
                begin
                    idx_next   = idx_inc[1:0];
                    state_next = S_TBM;
                end
                else
                begin
                    idx_next   = 2'd0;
                    state_next = S_AV1;
                end
            end
            S_AV1:
            begin
                cmd.op     = xxh32_pkg::OP_AV1;
                state_next = S_AV2;
            end
            S_AV2:
            begin
                cmd.op     = xxh32_pkg::OP_AV2;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = xxh32_pkg::OP_DONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for xxhash32_stream_hasher_core, a directed table then random messages
// every digest but the typed-in one is predicted by a behavioral xxhash32 model in this file
// depends on xxh32_pkg (primes, full byte count) and the core rtl

module tb;

    localparam int CLK_PERIOD    = 12;
    localparam int TOTAL_WORDS   = 1950;   // stimulus stops once this many words went in
    localparam int CALM_FROM     = 1750;   // no random idling on either side past this point
    localparam int LONG_HOLD     = 300;    // receiver back-pressure stretch, in cycles
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 40;

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;

    always #(CLK_PERIOD / 2) clk = ~clk;

    xxhash32_stream_hasher_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value)
    );

    // ------------------------------------------------------------------
    // directed table: seed writes and words; a digest is typed in only
    // where it is the well-known value (empty message, seed 0)
    // ------------------------------------------------------------------
    typedef enum logic {ROW_WORD, ROW_SEED} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;    // word data, or the seed for a seed row
        logic [2:0]  nbytes;
        logic        fin;
        logic        known;    // digest below is the expected one
        logic [31:0] digest;
    } plan_row_t;

    localparam int N_PLAN = 32;

    plan_row_t plan [N_PLAN] = '{
        '{ROW_SEED, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0},
        // empty message with seed 0
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h02CC_5D05},
        // single last words, byte counts one to four, junk above the count
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd2, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hA5A5_A5A5, 3'd3, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 32'h0},
        // oversized counts behave as four bytes
        '{ROW_WORD, 32'h5A5A_5A5A, 3'd5, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h1234_5678, 3'd6, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h8765_4321, 3'd7, 1'b1, 1'b0, 32'h0},
        // partial count on a word that is not last still counts four bytes
        '{ROW_WORD, 32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'hCAFE_F00D, 3'd3, 1'b1, 1'b0, 32'h0},
        // exactly one full stripe ending the message
        '{ROW_WORD, 32'h0000_0001, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h8000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h7FFF_FFFE, 3'd4, 1'b1, 1'b0, 32'h0},
        // stripe plus a two-byte tail
        '{ROW_WORD, 32'h1111_1111, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h2222_2222, 3'd7, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h3333_3333, 3'd1, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h4444_4444, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0, 32'h0},
        // max seed, empty message takes the short path
        '{ROW_SEED, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0},
        // seed change in the middle of a short message
        '{ROW_WORD, 32'h0102_0304, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0506_0708, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_SEED, 32'h1234_5678, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h090A_0B0C, 3'd2, 1'b1, 1'b0, 32'h0},
        // seed change after a stripe was mixed: lanes keep their values
        '{ROW_WORD, 32'hAAAA_AAAA, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h5555_5555, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0F0F_0F0F, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'hF0F0_F0F0, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_SEED, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h1357_2468, 3'd1, 1'b1, 1'b0, 32'h0}
    };

    // ------------------------------------------------------------------
    // digest predictor: its own seed, lanes, held words and length
    // ------------------------------------------------------------------
    logic [31:0] hash_seed;
    logic [31:0] lane [4];
    logic [31:0] held_word [4];
    logic [1:0]  held_count;
    logic [31:0] msg_bytes;
    logic        stripe_mixed;

    logic [31:0] expected_hash [$];   // digests still owed by the dut
    logic [31:0] want_hash;
    int          err_count;
    int          sent_words;

    // pacing controls for the sender and the receiver
    bit calm;
    bit gaps_on;
    bit stall_on;
    bit long_hold_req;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned r);
        logic [63:0] d;
        d = {v, v} << r;
        return d[63:32];
    endfunction

    function automatic logic [31:0] lane_mix(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] t;
        t = acc + w * xxh32_pkg::PRIME2;
        return rot_left(t, 13) * xxh32_pkg::PRIME1;
    endfunction

    function automatic logic [31:0] final_mix(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> 15);
        x = x * xxh32_pkg::PRIME2;
        x = x ^ (x >> 13);
        x = x * xxh32_pkg::PRIME3;
        return x ^ (x >> 16);
    endfunction

    task automatic restart_message();
        lane[0]      = hash_seed + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
        lane[1]      = hash_seed + xxh32_pkg::PRIME2;
        lane[2]      = hash_seed;
        lane[3]      = hash_seed - xxh32_pkg::PRIME1;
        held_count   = 2'd0;
        msg_bytes    = 32'd0;
        stripe_mixed = 1'b0;
    endtask

    // advance the predictor by one accepted word; a last word yields a digest
    task automatic absorb_word(input logic [31:0] d, input logic [2:0] bc, input logic fin,
                               output logic got, output logic [31:0] h);
        logic [2:0]  n;
        logic [31:0] acc;
        int          i;
        n = (fin && bc <= xxh32_pkg::FULL_COUNT) ? bc : xxh32_pkg::FULL_COUNT;
        msg_bytes = msg_bytes + 32'(n);
        if (n == xxh32_pkg::FULL_COUNT)
        begin
            if (held_count == 2'd3)
            begin
                // fourth word completes the stripe and goes straight into lane 3
                lane[0]      = lane_mix(lane[0], held_word[0]);
                lane[1]      = lane_mix(lane[1], held_word[1]);
                lane[2]      = lane_mix(lane[2], held_word[2]);
                lane[3]      = lane_mix(lane[3], d);
                stripe_mixed = 1'b1;
                held_count   = 2'd0;
            end
            else
            begin
                held_word[held_count] = d;
                held_count            = held_count + 2'd1;
            end
        end
        got = fin;
        h   = 32'h0;
        if (fin)
        begin
            if (stripe_mixed)
                acc = rot_left(lane[0], 1) + rot_left(lane[1], 7) +
                      rot_left(lane[2], 12) + rot_left(lane[3], 18);
            else
                acc = hash_seed + xxh32_pkg::PRIME5;
            acc = acc + msg_bytes;
            for (i = 0; i < held_count; i++)
            begin
                acc = acc + held_word[i] * xxh32_pkg::PRIME3;
                acc = rot_left(acc, 17) * xxh32_pkg::PRIME4;
            end
            if (n < xxh32_pkg::FULL_COUNT)
            begin
                for (i = 0; i < n; i++)
                begin
                    acc = acc + ((d >> (8 * i)) & 32'hFF) * xxh32_pkg::PRIME5;
                    acc = rot_left(acc, 11) * xxh32_pkg::PRIME1;
                end
            end
            h = final_mix(acc);
            restart_message();
        end
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    endtask

    // hold a word on the input channel until the transaction completes
    task automatic offer_word(input logic [31:0] d, input logic [2:0] bc, input logic fin,
                              input logic known, input logic [31:0] known_hash);
        logic        got;
        logic [31:0] h;
        in_valid   <= 1'b1;
        data_word  <= d;
        byte_count <= bc;
        last       <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_word(d, bc, fin, got, h);
        if (got)
            expected_hash.push_back(known ? known_hash : h);
        sent_words++;
    endtask

    // random burst of idle cycles on the input channel
    task automatic maybe_pause();
        if (!calm && gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // stop sending, let every owed digest out, then let the core settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hash.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        // the lanes are reloaded only if the message has not started yet
        hash_seed = v;
        if (held_count == 2'd0 && msg_bytes == 32'd0 && !stripe_mixed)
            restart_message();
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int          k;
        int          nwords;
        int          mid_at;
        int          msg_idx;
        logic [2:0]  bc;
        logic        fin;
        logic [31:0] new_seed;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'h0;
        in_valid      = 1'b0;
        data_word     = 32'h0;
        byte_count    = 3'd0;
        last          = 1'b0;
        err_count     = 0;
        sent_words    = 0;
        calm          = 1'b0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        hash_seed     = 32'h0;
        for (k = 0; k < 4; k++)
            held_word[k] = 32'h0;
        restart_message();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < N_PLAN; k++)
        begin
            if (plan[k].kind == ROW_SEED)
            begin
                wait_drained();
                write_seed(plan[k].value);
            end
            else
            begin
                offer_word(plan[k].value, plan[k].nbytes, plan[k].fin,
                           plan[k].known, plan[k].digest);
                maybe_pause();
            end
        end
        wait_drained();

        // random messages, mostly short, a few long enough for many stripes
        msg_idx = 0;
        while (sent_words < TOTAL_WORDS)
        begin
            calm = (sent_words >= CALM_FROM);
            // long receiver hold while the sender keeps offering words
            if (msg_idx == 60)
                long_hold_req = 1'b1;
            // sender pauses until the core has nothing left to deliver
            if (msg_idx == 120)
                wait_drained();
            if (msg_idx % 23 == 22)
            begin
                case ($urandom_range(0, 3))
                    0:       new_seed = 32'h0000_0000;
                    1:       new_seed = 32'hFFFF_FFFF;
                    default: new_seed = $urandom;
                endcase
                wait_drained();
                write_seed(new_seed);
            end
            if ($urandom_range(0, 9) == 0)
                gaps_on = !gaps_on;

            case ($urandom_range(0, 19))
                0:             nwords = $urandom_range(25, 64);
                1, 2, 3, 4, 5: nwords = $urandom_range(9, 24);
                default:       nwords = $urandom_range(1, 8);
            endcase
            // now and then the seed moves before a random word of the message
            mid_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, nwords - 1) : -1;

            for (k = 0; k < nwords; k++)
            begin
                if (k == mid_at)
                begin
                    wait_drained();
                    write_seed($urandom);
                end
                fin = (k == nwords - 1);
                if (fin || $urandom_range(0, 5) == 0)
                    bc = 3'($urandom_range(0, 7));
                else
                    bc = xxh32_pkg::FULL_COUNT;
                offer_word($urandom, bc, fin, 1'b0, 32'h0);
                maybe_pause();
            end
            msg_idx++;
        end

        in_valid <= 1'b0;
        while (expected_hash.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side: random stall bursts, stall-free stretches, one long hold
    // ------------------------------------------------------------------
    initial
    begin
        int cnt;
        bit hold_taken;
        out_ready  = 1'b0;
        stall_on   = 1'b1;
        hold_taken = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 199) == 0)
                stall_on = ($urandom_range(0, 2) != 0);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                // counted here so the sender keeps pushing and the core backs up
                for (cnt = 0; cnt < LONG_HOLD; cnt++)
                    @(posedge clk);
            end
            else if (!calm && stall_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: each digest transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hash.size() == 0)
            begin
                report_mismatch("digest with nothing pending", hash_value, 32'h0);
            end
            else
            begin
                want_hash = expected_hash.pop_front();
                if (hash_value !== want_hash)
                    report_mismatch("hash_value", hash_value, want_hash);
            end
        end
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #(12_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/xxh32_pkg.sv
rtl/xxh32_datapath.sv
rtl/xxh32_ctrl.sv
rtl/xxhash32_stream_hasher_core.sv
tb/tb.sv
